/* hw/rtl/ecal_pkg.sv */
// ----------------------------------------------------------------------------
// ecal_pkg
// Types, constants and small tables shared by the epoch to calendar unit.
// ----------------------------------------------------------------------------
`default_nettype none

package ecal_pkg;

   localparam int EPOCH_WIDTH = 35;
   localparam int SHIFTED_WIDTH = 34;
   localparam int YEAR_WIDTH = 12;

   localparam logic signed [EPOCH_WIDTH-1:0] MIN_SECONDS = -35'sd2208988800;
   localparam logic signed [EPOCH_WIDTH-1:0] MAX_SECONDS = 35'sd13569465599;
   localparam logic [EPOCH_WIDTH-1:0] EPOCH_OFFSET = 35'd2208988800;

   localparam logic [SHIFTED_WIDTH-1:0] SECS_PER_DAY = 34'd86400;
   localparam logic [SHIFTED_WIDTH-1:0] SECS_PER_HOUR = 34'd3600;
   localparam logic [SHIFTED_WIDTH-1:0] SECS_PER_MIN = 34'd60;
   localparam logic [SHIFTED_WIDTH-1:0] YEAR_SECS_LEAP = 34'd31622400;
   localparam logic [SHIFTED_WIDTH-1:0] YEAR_SECS_COMMON = 34'd31536000;

   localparam logic [YEAR_WIDTH-1:0] FIRST_YEAR = 12'd1900;
   localparam logic [YEAR_WIDTH-1:0] LAST_YEAR = 12'd2399;
   localparam logic [3:0] LAST_MONTH = 4'd11;
   localparam logic [6:0] CENTURY_LAST = 7'd99;
   localparam logic [8:0] QUAD_CENTURY_LAST = 9'd399;
   // 1900 sits at offset 300 within its 400-year cycle.
   localparam logic [8:0] QUAD_CENTURY_START = 9'd300;
   // 1900-01-01 was a Monday.
   localparam logic [2:0] FIRST_WEEKDAY_BIAS = 3'd1;

   typedef struct packed {
      logic signed [34:0] epoch_seconds;
   } req_type;

   typedef struct packed {
      logic        in_range;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day_of_month;
      logic [8:0]  day_of_year;
      logic [2:0]  weekday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_YEARS,
      ST_MONTHS,
      ST_DAYS,
      ST_HOURS,
      ST_MINUTES,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic year_step;
      logic month_step;
      logic day_step;
      logic hour_step;
      logic minute_step;
      logic publish;
   } cmd_type;

   typedef struct packed {
      logic range_ok;
      logic year_more;
      logic month_more;
      logic day_more;
      logic hour_more;
      logic minute_more;
   } status_type;

   function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
      logic [4:0] len;
      case (month)
         4'd0, 4'd2, 4'd4, 4'd6, 4'd7, 4'd9, 4'd11: len = 5'd31;
         4'd3, 4'd5, 4'd8, 4'd10:                   len = 5'd30;
         4'd1:                                      len = leap ? 5'd29 : 5'd28;
         default:                                   len = 5'd31;
      endcase
      return len;
   endfunction

   function automatic logic [SHIFTED_WIDTH-1:0] month_seconds(input logic [4:0] len);
      logic [SHIFTED_WIDTH-1:0] secs;
      case (len)
         5'd28:   secs = 34'd2419200;
         5'd29:   secs = 34'd2505600;
         5'd30:   secs = 34'd2592000;
         default: secs = 34'd2678400;
      endcase
      return secs;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/ecal_req_if.sv */
// ----------------------------------------------------------------------------
// ecal_req_if
// Valid/ready channel carrying one conversion request.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecal_req_if;
   import ecal_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ecal_rsp_if.sv */
// ----------------------------------------------------------------------------
// ecal_rsp_if
// Valid/ready channel carrying one calendar breakdown.
// ----------------------------------------------------------------------------
`default_nettype none

interface ecal_rsp_if;
   import ecal_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/ecal_datapath.sv */
// ----------------------------------------------------------------------------
// ecal_datapath
// Working registers: year, month and day walks over the seconds count, time
// of day split, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_datapath (
   input  wire logic               clock,
   input  wire ecal_pkg::req_type  req_data,
   input  wire ecal_pkg::cmd_type  cmd,
   output      ecal_pkg::status_type status,
   output      ecal_pkg::rsp_type  rsp_data
);
   import ecal_pkg::*;

   logic [SHIFTED_WIDTH-1:0] secs_ff, secs_in;
   logic [YEAR_WIDTH-1:0]    year_ff, year_in;
   logic [1:0]               y4_ff, y4_in;
   logic [6:0]               y100_ff, y100_in;
   logic [8:0]               y400_ff, y400_in;
   logic [3:0]               month_ff, month_in;
   logic [4:0]               mday_ff, mday_in;
   logic [8:0]               yday_ff, yday_in;
   logic [2:0]               wday_ff, wday_in;
   logic [4:0]               hour_ff, hour_in;
   logic [5:0]               minute_ff, minute_in;
   logic                     in_range_ff, in_range_in;
   rsp_type                  rsp_ff, rsp_in;

   logic [EPOCH_WIDTH-1:0]   shifted;
   logic                     leap;
   logic [SHIFTED_WIDTH-1:0] year_secs;
   logic [4:0]               mon_len;
   logic [SHIFTED_WIDTH-1:0] mon_secs;
   logic [2:0]               year_shift;
   logic [2:0]               month_shift;

   function automatic logic [2:0] wday_add(input logic [2:0] wday, input logic [2:0] shift);
      logic [3:0] sum;
      sum = {1'b0, wday} + {1'b0, shift};
      return (sum >= 4'd7) ? 3'(sum - 4'd7) : sum[2:0];
   endfunction

   assign shifted = req_data.epoch_seconds + EPOCH_OFFSET;

   assign leap = (y4_ff == 2'd0) && ((y100_ff != 7'd0) || (y400_ff == 9'd0));
   assign year_secs = leap ? YEAR_SECS_LEAP : YEAR_SECS_COMMON;
   assign mon_len = month_days(month_ff, leap);
   assign mon_secs = month_seconds(mon_len);
   // A common year moves the weekday by one, a leap year by two; a month
   // moves it by its length beyond four whole weeks.
   assign year_shift = leap ? 3'd2 : 3'd1;
   assign month_shift = 3'(mon_len - 5'd28);

   always_comb begin
      status.range_ok = (req_data.epoch_seconds >= MIN_SECONDS) &&
                        (req_data.epoch_seconds <= MAX_SECONDS);
      status.year_more = (year_ff < LAST_YEAR) && (secs_ff >= year_secs);
      status.month_more = (month_ff < LAST_MONTH) && (secs_ff >= mon_secs);
      status.day_more = (secs_ff >= SECS_PER_DAY);
      status.hour_more = (secs_ff >= SECS_PER_HOUR);
      status.minute_more = (secs_ff >= SECS_PER_MIN);
   end

   always_comb begin
      secs_in = secs_ff;
      year_in = year_ff;
      y4_in = y4_ff;
      y100_in = y100_ff;
      y400_in = y400_ff;
      month_in = month_ff;
      mday_in = mday_ff;
      yday_in = yday_ff;
      wday_in = wday_ff;
      hour_in = hour_ff;
      minute_in = minute_ff;
      in_range_in = in_range_ff;
      rsp_in = rsp_ff;

      if (cmd.load) begin
         secs_in = shifted[SHIFTED_WIDTH-1:0];
         year_in = FIRST_YEAR;
         y4_in = '0;
         y100_in = '0;
         y400_in = QUAD_CENTURY_START;
         month_in = '0;
         mday_in = '0;
         yday_in = '0;
         wday_in = FIRST_WEEKDAY_BIAS;
         hour_in = '0;
         minute_in = '0;
         in_range_in = status.range_ok;
      end

      if (cmd.year_step) begin
         secs_in = secs_ff - year_secs;
         year_in = year_ff + 12'd1;
         y4_in = y4_ff + 2'd1;
         y100_in = (y100_ff == CENTURY_LAST) ? 7'd0 : y100_ff + 7'd1;
         y400_in = (y400_ff == QUAD_CENTURY_LAST) ? 9'd0 : y400_ff + 9'd1;
         wday_in = wday_add(wday_ff, year_shift);
      end

      if (cmd.month_step) begin
         secs_in = secs_ff - mon_secs;
         month_in = month_ff + 4'd1;
         yday_in = yday_ff + {4'b0000, mon_len};
         wday_in = wday_add(wday_ff, month_shift);
      end

      if (cmd.day_step) begin
         secs_in = secs_ff - SECS_PER_DAY;
         mday_in = mday_ff + 5'd1;
         yday_in = yday_ff + 9'd1;
         wday_in = wday_add(wday_ff, 3'd1);
      end

      if (cmd.hour_step) begin
         secs_in = secs_ff - SECS_PER_HOUR;
         hour_in = hour_ff + 5'd1;
      end

      if (cmd.minute_step) begin
         secs_in = secs_ff - SECS_PER_MIN;
         minute_in = minute_ff + 6'd1;
      end

      if (cmd.publish) begin
         if (in_range_ff) begin
            rsp_in.in_range = 1'b1;
            rsp_in.year = year_ff;
            rsp_in.month = month_ff;
            rsp_in.day_of_month = mday_ff + 5'd1;
            rsp_in.day_of_year = yday_ff;
            rsp_in.weekday = wday_ff;
            rsp_in.hour = hour_ff;
            rsp_in.minute = minute_ff;
            rsp_in.second = secs_ff[5:0];
         end else begin
            rsp_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      secs_ff <= secs_in;
      year_ff <= year_in;
      y4_ff <= y4_in;
      y100_ff <= y100_in;
      y400_ff <= y400_in;
      month_ff <= month_in;
      mday_ff <= mday_in;
      yday_ff <= yday_in;
      wday_ff <= wday_in;
      hour_ff <= hour_in;
      minute_ff <= minute_in;
      in_range_ff <= in_range_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

/* hw/rtl/ecal_ctrl.sv */
// ----------------------------------------------------------------------------
// ecal_ctrl
// Sequencer for the conversion phases and owner of the result valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module ecal_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   input  wire ecal_pkg::status_type   status,
   output      ecal_pkg::cmd_type      cmd
);
   import ecal_pkg::*;

   ctrl_state_type             state_ff, state_in;
   logic                       rsp_full_ff, rsp_full_in;
   logic                       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept = req_valid && req_ready;
   assign rsp_valid = rsp_full_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_full_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_full_ff <= rsp_full_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               // An out of range request skips straight to the result.
               state_in = status.range_ok ? ST_YEARS : ST_DONE;
            end
         end
         ST_YEARS: begin
            if (status.year_more) begin
               cmd.year_step = 1'b1;
            end else begin
               state_in = ST_MONTHS;
            end
         end
         ST_MONTHS: begin
            if (status.month_more) begin
               cmd.month_step = 1'b1;
            end else begin
               state_in = ST_DAYS;
            end
         end
         ST_DAYS: begin
            if (status.day_more) begin
               cmd.day_step = 1'b1;
            end else begin
               state_in = ST_HOURS;
            end
         end
         ST_HOURS: begin
            if (status.hour_more) begin
               cmd.hour_step = 1'b1;
            end else begin
               state_in = ST_MINUTES;
            end
         end
         ST_MINUTES: begin
            if (status.minute_more) begin
               cmd.minute_step = 1'b1;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_full_ff || rsp_ready) begin
               cmd.publish = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.publish) begin
         rsp_full_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_full_in = 1'b0;
      end else begin
         rsp_full_in = rsp_full_ff;
      end
   end

   // A result must never overwrite one that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      cmd.publish |-> (!rsp_full_ff || rsp_ready))
      else $error("result register overwritten while full");

   // An out of range request goes straight to the result phase.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !status.range_ok) |=> (state_ff == ST_DONE))
      else $error("out of range request did not skip the walks");

   // A waiting result stays valid until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before it was taken");

   // An accepted request starts the year walk, or the result phase if out of range.
   assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_YEARS || state_ff == ST_DONE))
      else $error("accepted request did not start a conversion");

endmodule

`default_nettype wire

/* hw/rtl/epoch_seconds_to_calendar_unit.sv */
// Sequence: an out of range request goes from accept straight to publishing the
// result; otherwise the unit walks years, months, days, hours and minutes one step
// at a time (at most 499, 11, 30, 23 and 59 steps), leaves each walk, then publishes.
// Throughput: one request per conversion; the next request is taken as soon as
// the result is in the output register, even while that result waits.
// Reset: synchronous, active high; clears the sequencer and the result valid.
`default_nettype none

// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit
// Breaks signed Unix seconds into a UTC calendar date and time of day.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
   input wire logic clock,
   input wire logic reset,
   ecal_req_if.sink   req_port,
   ecal_rsp_if.source rsp_port
);
   import ecal_pkg::*;

   cmd_type    cmd;
   status_type status;

   ecal_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_port.ready),
      .rsp_valid (rsp_port.valid),
      .rsp_ready (rsp_port.ready),
      .status    (status),
      .cmd       (cmd)
   );

   ecal_datapath u_datapath (
      .clock    (clock),
      .req_data (req_port.data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_port.data)
   );

endmodule

`default_nettype wire

/* verif/ecal_calendar_check_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecal_calendar_check_pkg
// Calendar arithmetic for checking the epoch to calendar unit, and a
// scoreboard that predicts each breakdown and compares it with the block.
// ----------------------------------------------------------------------------
package ecal_calendar_check_pkg;
   import ecal_pkg::*;

   localparam longint FIRST_SECOND = -64'sd2208988800;
   localparam longint LAST_SECOND = 64'sd13569465599;
   localparam longint DAY_SECONDS = 64'sd86400;
   localparam int BASE_YEAR = 1900;
   localparam int END_YEAR = 2399;
   localparam int MONTH_TABLE[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   function automatic bit is_leap(int yr);
      if (yr % 4 != 0) return 1'b0;
      if (yr % 100 != 0) return 1'b1;
      return (yr % 400) == 0;
   endfunction

   function automatic int year_days(int yr);
      return is_leap(yr) ? 366 : 365;
   endfunction

   function automatic int month_length(int yr, int mon);
      if (mon == 1 && is_leap(yr)) return 29;
      return MONTH_TABLE[mon];
   endfunction

   function automatic rsp_type expected_calendar(logic signed [EPOCH_WIDTH-1:0] secs);
      rsp_type bd;
      longint t;
      longint days;
      longint tod;
      int yr;
      int mon;
      bd = '0;
      t = longint'(secs);
      if (t < FIRST_SECOND || t > LAST_SECOND) return bd;
      // Counting from the first supported day keeps the division non-negative.
      t = t - FIRST_SECOND;
      days = t / DAY_SECONDS;
      tod = t % DAY_SECONDS;
      // The first supported day was a Monday.
      bd.weekday = 3'((days + 1) % 7);
      yr = BASE_YEAR;
      while (yr < END_YEAR && days >= year_days(yr)) begin
         days = days - year_days(yr);
         yr++;
      end
      bd.day_of_year = 9'(days);
      mon = 0;
      while (mon < 11 && days >= month_length(yr, mon)) begin
         days = days - month_length(yr, mon);
         mon++;
      end
      bd.in_range = 1'b1;
      bd.year = 12'(yr);
      bd.month = 4'(mon);
      bd.day_of_month = 5'(days + 1);
      bd.hour = 5'(tod / 3600);
      bd.minute = 6'((tod % 3600) / 60);
      bd.second = 6'(tod % 60);
      return bd;
   endfunction

   class calendar_scoreboard;
      rsp_type pending_dates[$];
      int mismatches = 0;

      function void report(string what, rsp_type want, rsp_type got);
         mismatches++;
         if (mismatches <= 10) begin
            $display("[%0t] %s", $time, what);
            $display("   expected ok=%0d %0d-%0d-%0d yday=%0d wday=%0d %0d:%0d:%0d",
                     want.in_range, want.year, want.month, want.day_of_month,
                     want.day_of_year, want.weekday, want.hour, want.minute, want.second);
            $display("   actual   ok=%0d %0d-%0d-%0d yday=%0d wday=%0d %0d:%0d:%0d",
                     got.in_range, got.year, got.month, got.day_of_month,
                     got.day_of_year, got.weekday, got.hour, got.minute, got.second);
         end
      endfunction

      function void note_request(req_type rq);
         pending_dates.push_back(expected_calendar(rq.epoch_seconds));
      endfunction

      function void check_response(rsp_type got);
         rsp_type want;
         bit differs;
         if (pending_dates.size() == 0) begin
            report("unexpected calendar result", '0, got);
            return;
         end
         want = pending_dates.pop_front();
         differs = (got.in_range != want.in_range) || (got.year != want.year) ||
                   (got.month != want.month) || (got.day_of_month != want.day_of_month) ||
                   (got.day_of_year != want.day_of_year) || (got.weekday != want.weekday) ||
                   (got.hour != want.hour) || (got.minute != want.minute) ||
                   (got.second != want.second);
         if (differs) report("calendar result mismatch", want, got);
      endfunction

      function int outstanding();
         return pending_dates.size();
      endfunction
   endclass

endpackage

/* verif/tb_epoch_seconds_to_calendar_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_unit
// Drives signed epoch seconds into the calendar unit under random flow control
// and checks every breakdown against a predicted calendar date and time.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar_unit;
   import ecal_pkg::*;
   import ecal_calendar_check_pkg::*;

   localparam int RANDOM_REQUESTS = 950;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 700;
   localparam longint SPAN_SECONDS = LAST_SECOND - FIRST_SECOND + 1;

   logic clock;
   logic reset;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int stall_cycles = 0;
   calendar_scoreboard sb;

   ecal_req_if req_ch ();
   ecal_rsp_if rsp_ch ();

   epoch_seconds_to_calendar_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Results are checked before requests are noted, so that a result with
   // nothing waiting is caught even when a request lands on the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) sb.check_response(rsp_ch.data);
         if (req_ch.valid && req_ch.ready) sb.note_request(req_ch.data);
         if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("Verification failed");
      $finish;
   end

   function automatic longint year_start_seconds(int yr);
      longint days;
      days = 0;
      for (int y = BASE_YEAR; y < yr; y++) days += year_days(y);
      return FIRST_SECOND + days * DAY_SECONDS;
   endfunction

   function automatic longint random_epoch();
      longint unsigned raw;
      longint base;
      int pick;
      raw = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 75) return FIRST_SECOND + longint'(raw % SPAN_SECONDS);
      if (pick < 90) begin
         // Near a new year or the start of March, where leap handling matters.
         base = year_start_seconds($urandom_range(END_YEAR + 1, BASE_YEAR));
         if ($urandom_range(1)) base += (59 + is_leap($urandom_range(1) ? 2000 : 1900)) *
                                        DAY_SECONDS;
         return base + $urandom_range(2 * 86400) - 86400;
      end
      // Any pattern of the 35-bit field, mostly out of range.
      return longint'({{29{raw[34]}}, raw[34:0]});
   endfunction

   // The phase of flow control follows the number of requests sent so far.
   task automatic set_idling(int sent, int total);
      if (sent < total / 3) begin
         sender_idle_pct = 16;
         receiver_idle_pct = 78;
      end else if (sent < 2 * total / 3) begin
         sender_idle_pct = 78;
         receiver_idle_pct = 16;
      end else begin
         sender_idle_pct = 0;
         receiver_idle_pct = 0;
      end
   endtask

   task automatic send_request(longint secs);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data.epoch_seconds <= secs[EPOCH_WIDTH-1:0];
      do @(posedge clock); while (!req_ch.ready);
   endtask

   initial begin
      longint directed[$];
      int total;
      sb = new;
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.data <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      directed = '{FIRST_SECOND, LAST_SECOND, FIRST_SECOND - 1, LAST_SECOND + 1,
                   -64'sd17179869184, 64'sd17179869183, 0, -1, 1, -86400, -86401,
                   // Leap day in a quad-century year, and the day after a
                   // century that is not leap.
                   64'sd951782400, 64'sd951868799,
                   year_start_seconds(1900) + 59 * DAY_SECONDS - 1,
                   year_start_seconds(2100) + 59 * DAY_SECONDS,
                   year_start_seconds(2000) - 1, year_start_seconds(2000),
                   year_start_seconds(2397) - 1, year_start_seconds(2399),
                   year_start_seconds(1904) + 60 * DAY_SECONDS - 1,
                   year_start_seconds(2020) + 335 * DAY_SECONDS + 86399,
                   year_start_seconds(2200) + 364 * DAY_SECONDS + 43261};
      total = directed.size() + RANDOM_REQUESTS;

      foreach (directed[i]) begin
         set_idling(i, total);
         send_request(directed[i]);
      end
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         set_idling(directed.size() + i, total);
         send_request(random_epoch());
      end
      req_ch.valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
